/* rtl/drm_pkg.sv */
// Package for the dirty rectangle merge table: widths, codes and shared types.
package drm_pkg;

	// Field widths
	localparam int COORD_W   = 15;
	localparam int RECT_IN_W = 16;
	localparam int ENTRY_W   = 3;
	localparam int CNT_OUT_W = 4;
	localparam int OUTC_W    = 3;

	// Table depth default
	localparam int MAX_REGIONS_DEF = 8;

	// Configuration port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [COORD_W-1:0] WIDTH_RST  = 15'd480;
	localparam logic [COORD_W-1:0] HEIGHT_RST = 15'd480;

	// Action codes
	localparam logic [1:0] ACT_MARK  = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// Mark outcome codes
	localparam logic [OUTC_W-1:0] OUT_NONE     = 3'd0;
	localparam logic [OUTC_W-1:0] OUT_MERGED   = 3'd1;
	localparam logic [OUTC_W-1:0] OUT_APPENDED = 3'd2;
	localparam logic [OUTC_W-1:0] OUT_OVERFLOW = 3'd3;
	localparam logic [OUTC_W-1:0] OUT_DISABLED = 3'd4;

	// One stored rectangle, inclusive corners, already clipped
	typedef struct packed {
		logic [COORD_W-1:0] l;
		logic [COORD_W-1:0] t;
		logic [COORD_W-1:0] r;
		logic [COORD_W-1:0] b;
	} box_t;

	// Configuration register set
	typedef struct packed {
		logic               enable;
		logic [COORD_W-1:0] disp_width;
		logic [COORD_W-1:0] disp_height;
	} cfg_t;

endpackage

/* rtl/drm_if.sv */
// Handshake channels for the dirty rectangle merge table: command beats and result beats.
interface drm_item_if
	import drm_pkg::*;
();
	logic                        valid;
	logic                        ready;
	logic [1:0]                  action;
	logic signed [RECT_IN_W-1:0] rect_left;
	logic signed [RECT_IN_W-1:0] rect_top;
	logic signed [RECT_IN_W-1:0] rect_right;
	logic signed [RECT_IN_W-1:0] rect_bottom;
	logic [ENTRY_W-1:0]          entry_index;

	modport source (
		output valid, action, rect_left, rect_top, rect_right, rect_bottom, entry_index,
		input  ready
	);
	modport sink (
		input  valid, action, rect_left, rect_top, rect_right, rect_bottom, entry_index,
		output ready
	);
endinterface

interface drm_result_if
	import drm_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 refresh_request;
	logic                 redraw_all;
	logic [CNT_OUT_W-1:0] region_count;
	logic [OUTC_W-1:0]    mark_outcome;
	logic [COORD_W-1:0]   out_left;
	logic [COORD_W-1:0]   out_top;
	logic [COORD_W-1:0]   out_right;
	logic [COORD_W-1:0]   out_bottom;
	logic                 out_valid;

	modport source (
		output valid, refresh_request, redraw_all, region_count, mark_outcome,
		       out_left, out_top, out_right, out_bottom, out_valid,
		input  ready
	);
	modport sink (
		input  valid, refresh_request, redraw_all, region_count, mark_outcome,
		       out_left, out_top, out_right, out_bottom, out_valid,
		output ready
	);
endinterface

/* rtl/drm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module drm_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 8,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/drm_box.sv */
// Shared rectangle unit: touch test and bounding-box merge of two rectangles.
module drm_box
	import drm_pkg::*;
(
	input  box_t a,
	input  box_t b,
	output logic touch,
	output box_t merged
);

	logic [COORD_W:0] a_r1, a_b1, b_r1, b_b1;

	// Edges grown by one pixel so that a zero gap counts as touching
	assign a_r1 = {1'b0, a.r} + (COORD_W+1)'(1);
	assign a_b1 = {1'b0, a.b} + (COORD_W+1)'(1);
	assign b_r1 = {1'b0, b.r} + (COORD_W+1)'(1);
	assign b_b1 = {1'b0, b.b} + (COORD_W+1)'(1);

	assign touch = !((a_r1 < {1'b0, b.l}) || ({1'b0, a.l} > b_r1) ||
	                 (a_b1 < {1'b0, b.t}) || ({1'b0, a.t} > b_b1));

	// Bounding box
	always_comb begin
		merged.l = (a.l < b.l) ? a.l : b.l;
		merged.t = (a.t < b.t) ? a.t : b.t;
		merged.r = (a.r > b.r) ? a.r : b.r;
		merged.b = (a.b > b.b) ? a.b : b.b;
	end

endmodule

/* rtl/drm_apb.sv */
// APB configuration registers: enable and screen size used for clipping.
module drm_apb
	import drm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic               enable_q;
	logic [COORD_W-1:0] width_q;
	logic [COORD_W-1:0] height_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_ENABLE: enable_q <= pwdata[0];
				REG_WIDTH:  width_q  <= pwdata[COORD_W-1:0];
				REG_HEIGHT: height_q <= pwdata[COORD_W-1:0];
				default:    ;
			endcase
		end
	end

	// Read-back
	always_comb begin
		unique case (paddr[3:2])
			REG_ENABLE: prdata = {{(APB_DW-1){1'b0}}, enable_q};
			REG_WIDTH:  prdata = {{(APB_DW-COORD_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(APB_DW-COORD_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.enable      = enable_q;
	assign cfg.disp_width  = width_q;
	assign cfg.disp_height = height_q;

endmodule

/* rtl/dirty_rect_merge_table.sv */
// Dirty rectangle merge table top: sequencer, table RAM, shared rectangle unit, config.
// An on-screen mark into a non-empty table scans the stored entries in order, one table
// entry per cycle through one RAM read port and one touch/merge unit, stopping at the
// first entry that it touches.
// One command at a time; the next is taken the cycle after its result is registered.
// Reset: count and full-refresh flag cleared, enable=1, screen 480x480; table unset.
module dirty_rect_merge_table
	import drm_pkg::*;
#(
	parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	drm_item_if.sink          item,
	drm_result_if.source      result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int CNT_W = $clog2(MAX_REGIONS + 1);
	localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int XW    = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
	localparam int SW    = COORD_W + 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLIP,
		S_SCAN,
		S_READ,
		S_DONE
	} state_t;

	cfg_t cfg;

	state_t                      state_q;
	logic signed [RECT_IN_W-1:0] rect_l_q, rect_t_q, rect_r_q, rect_b_q;
	box_t                        clip_q;
	logic [IDX_W-1:0]            scan_q;
	logic [CNT_W-1:0]            count_q;
	logic                        full_q;

	// Result staging
	logic                        res_req_q;
	logic [OUTC_W-1:0]           res_outcome_q;
	logic                        res_bvalid_q;
	box_t                        res_box_q;

	// Output register
	logic                        o_vld_q;
	logic                        o_req_q;
	logic                        o_full_q;
	logic [CNT_OUT_W-1:0]        o_cnt_q;
	logic [OUTC_W-1:0]           o_outcome_q;
	logic                        o_bvalid_q;
	box_t                        o_box_q;

	// Clipping
	logic signed [SW-1:0] w_m1, h_m1, r_ext, b_ext, c_r, c_b;
	logic [COORD_W-1:0]   c_l, c_t;
	logic                 clip_ok;
	box_t                 clip_c;

	// Table access
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr, ram_raddr;
	box_t                 ram_wdata;
	logic [$bits(box_t)-1:0] ram_rdata;
	box_t                 entry_rd;
	logic                 touch;
	box_t                 merged;
	logic                 scan_last;
	logic                 tbl_full;
	logic                 rd_hit;

	drm_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Clip the latched rectangle to the screen
	always_comb begin
		w_m1  = $signed({2'b00, cfg.disp_width}) - SW'(1);
		h_m1  = $signed({2'b00, cfg.disp_height}) - SW'(1);
		r_ext = SW'(rect_r_q);
		b_ext = SW'(rect_b_q);
		c_l   = rect_l_q[RECT_IN_W-1] ? '0 : rect_l_q[COORD_W-1:0];
		c_t   = rect_t_q[RECT_IN_W-1] ? '0 : rect_t_q[COORD_W-1:0];
		c_r   = (r_ext < w_m1) ? r_ext : w_m1;
		c_b   = (b_ext < h_m1) ? b_ext : h_m1;
		clip_ok = ($signed({2'b00, c_l}) <= c_r) && ($signed({2'b00, c_t}) <= c_b);
		clip_c.l = c_l;
		clip_c.t = c_t;
		clip_c.r = c_r[COORD_W-1:0];
		clip_c.b = c_b[COORD_W-1:0];
	end

	assign entry_rd  = box_t'(ram_rdata);
	assign scan_last = (CNT_W'(scan_q) + CNT_W'(1)) == count_q;
	assign tbl_full  = count_q == CNT_W'(MAX_REGIONS);
	assign rd_hit    = XW'(item.entry_index) < XW'(count_q);

	drm_box u_box (
		.a      (clip_q),
		.b      (entry_rd),
		.touch  (touch),
		.merged (merged)
	);

	// Table RAM control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = clip_c;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: ram_raddr = IDX_W'(item.entry_index);
			S_CLIP: begin
				ram_raddr = '0;
				if (clip_ok && (count_q == '0)) begin
					ram_we = 1'b1;
				end
			end
			S_SCAN: begin
				ram_raddr = scan_q + IDX_W'(1);
				if (touch) begin
					ram_we    = 1'b1;
					ram_waddr = scan_q;
					ram_wdata = merged;
				end else if (scan_last && !tbl_full) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[IDX_W-1:0];
					ram_wdata = clip_q;
				end
			end
			default: ram_raddr = '0;
		endcase
	end

	drm_ram #(
		.WIDTH ($bits(box_t)),
		.DEPTH (MAX_REGIONS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			rect_l_q      <= '0;
			rect_t_q      <= '0;
			rect_r_q      <= '0;
			rect_b_q      <= '0;
			clip_q        <= '0;
			scan_q        <= '0;
			count_q       <= '0;
			full_q        <= 1'b0;
			res_req_q     <= 1'b0;
			res_outcome_q <= OUT_NONE;
			res_bvalid_q  <= 1'b0;
			res_box_q     <= '0;
			o_vld_q       <= 1'b0;
			o_req_q       <= 1'b0;
			o_full_q      <= 1'b0;
			o_cnt_q       <= '0;
			o_outcome_q   <= OUT_NONE;
			o_bvalid_q    <= 1'b0;
			o_box_q       <= '0;
		end else begin
			// a result register reloaded in S_DONE stays valid
			if (result.valid && result.ready && (state_q != S_DONE)) begin
				o_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						rect_l_q      <= item.rect_left;
						rect_t_q      <= item.rect_top;
						rect_r_q      <= item.rect_right;
						rect_b_q      <= item.rect_bottom;
						res_req_q     <= (item.action == ACT_MARK) && !cfg.enable;
						res_outcome_q <= ((item.action == ACT_MARK) && !cfg.enable) ?
						                 OUT_DISABLED : OUT_NONE;
						res_bvalid_q  <= 1'b0;
						res_box_q     <= '0;
						unique case (item.action)
							ACT_MARK: begin
								if (!cfg.enable) begin
									full_q  <= 1'b1;
									count_q <= '0;
									state_q <= S_DONE;
								end else begin
									state_q <= S_CLIP;
								end
							end
							ACT_CLEAR: begin
								count_q <= '0;
								full_q  <= 1'b0;
								state_q <= S_DONE;
							end
							ACT_READ: state_q <= rd_hit ? S_READ : S_DONE;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_CLIP: begin
					clip_q <= clip_c;
					scan_q <= '0;
					if (!clip_ok) begin
						state_q <= S_DONE;
					end else if (count_q == '0) begin
						// empty table: append straight away
						count_q       <= count_q + CNT_W'(1);
						res_req_q     <= 1'b1;
						res_outcome_q <= OUT_APPENDED;
						res_bvalid_q  <= 1'b1;
						res_box_q     <= clip_c;
						state_q       <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (touch) begin
						res_req_q     <= 1'b1;
						res_outcome_q <= OUT_MERGED;
						res_bvalid_q  <= 1'b1;
						res_box_q     <= merged;
						state_q       <= S_DONE;
					end else if (scan_last) begin
						res_req_q <= 1'b1;
						if (tbl_full) begin
							full_q        <= 1'b1;
							res_outcome_q <= OUT_OVERFLOW;
						end else begin
							count_q       <= count_q + CNT_W'(1);
							res_outcome_q <= OUT_APPENDED;
							res_bvalid_q  <= 1'b1;
							res_box_q     <= clip_q;
						end
						state_q <= S_DONE;
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				S_READ: begin
					res_bvalid_q <= 1'b1;
					res_box_q    <= entry_rd;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!o_vld_q || result.ready) begin
						o_vld_q     <= 1'b1;
						o_req_q     <= res_req_q;
						o_full_q    <= full_q;
						o_cnt_q     <= CNT_OUT_W'(count_q);
						o_outcome_q <= res_outcome_q;
						o_bvalid_q  <= res_bvalid_q;
						o_box_q     <= res_box_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item.ready = (state_q == S_IDLE);

	assign result.valid           = o_vld_q;
	assign result.refresh_request = o_req_q;
	assign result.redraw_all      = o_full_q;
	assign result.region_count    = o_cnt_q;
	assign result.mark_outcome    = o_outcome_q;
	assign result.out_left        = o_box_q.l;
	assign result.out_top         = o_box_q.t;
	assign result.out_right       = o_box_q.r;
	assign result.out_bottom      = o_box_q.b;
	assign result.out_valid       = o_bvalid_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_REGIONS))
		else $error("stored count beyond table depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> state_q != S_IDLE)
		else $error("sequencer idle right after a command beat");

	a_zero_unused_rect: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.out_valid |->
		(result.out_left == '0) && (result.out_top == '0) &&
		(result.out_right == '0) && (result.out_bottom == '0))
		else $error("rectangle fields not zero on a beat without a rectangle");

	a_outcome_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && ((result.mark_outcome == OUT_OVERFLOW) ||
		(result.mark_outcome == OUT_DISABLED)) |->
		result.redraw_all && result.refresh_request && !result.out_valid)
		else $error("overflow or disabled mark without full refresh");

endmodule

/* bench/dirty_rect_merge_table_tb.sv */
// Self-checking testbench for the dirty rectangle merge table: predicted status per command.
`timescale 1ns / 100ps

module dirty_rect_merge_table_tb;
	import drm_pkg::*;

	localparam int          MAX_SLOTS  = MAX_REGIONS_DEF;
	localparam int          LONG_HOLD  = 300;
	localparam int          LIMIT      = 300000;
	localparam int          SETTLE_CYC = 16;
	localparam int          MAX_PRINTS = 60;
	localparam logic [1:0]  ACT_SPARE  = 2'd3;

	// One command beat
	typedef struct {
		logic [1:0]         action;
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic signed [15:0] right;
		logic signed [15:0] bottom;
		logic [ENTRY_W-1:0] idx;
	} rect_cmd_t;

	// One status beat
	typedef struct packed {
		logic                 req;
		logic                 full;
		logic [CNT_OUT_W-1:0] cnt;
		logic [OUTC_W-1:0]    outc;
		box_t                 box;
		logic                 vld;
	} table_status_t;

	// Tracks the dirty table and holds the statuses still owed by the block
	class dirty_table_tracker;
		box_t            slots [MAX_SLOTS];
		int              count;
		bit              full;
		bit              en;
		int              scr_w;
		int              scr_h;
		table_status_t   pending [$];
		int              errors;

		function new();
			count = 0;
			full  = 0;
			en    = 1;
			scr_w = 480;
			scr_h = 480;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [APB_DW-1:0] val);
			case (idx)
				REG_ENABLE: en = val[0];
				REG_WIDTH:  scr_w = int'(val[COORD_W-1:0]);
				REG_HEIGHT: scr_h = int'(val[COORD_W-1:0]);
				default: ;
			endcase
		endfunction

		function int lo(int a, int b);
			return (a < b) ? a : b;
		endfunction

		function int hi(int a, int b);
			return (a > b) ? a : b;
		endfunction

		// Work out the status an accepted command will produce
		function void note_command(rect_cmd_t c);
			table_status_t s;
			int cl, ct, cr, cb, el, et, er, eb, i;
			bit hit;
			box_t nb;
			s = '0;
			hit = 0;
			case (c.action)
				ACT_MARK: begin
					if (!en) begin
						full = 1;
						count = 0;
						s.req = 1;
						s.outc = OUT_DISABLED;
					end else begin
						// clip to the screen
						cl = hi(0, int'(c.left));
						ct = hi(0, int'(c.top));
						cr = lo(int'(c.right), scr_w - 1);
						cb = lo(int'(c.bottom), scr_h - 1);
						if (cl <= cr && ct <= cb) begin
							s.req = 1;
							// first stored entry that overlaps or touches takes the merge
							for (i = 0; i < count && !hit; i++) begin
								el = int'(slots[i].l);
								et = int'(slots[i].t);
								er = int'(slots[i].r);
								eb = int'(slots[i].b);
								if (!(cr < el - 1 || cl > er + 1 || cb < et - 1 || ct > eb + 1)) begin
									slots[i].l = COORD_W'(lo(el, cl));
									slots[i].t = COORD_W'(lo(et, ct));
									slots[i].r = COORD_W'(hi(er, cr));
									slots[i].b = COORD_W'(hi(eb, cb));
									s.box  = slots[i];
									s.vld  = 1;
									s.outc = OUT_MERGED;
									hit = 1;
								end
							end
							if (!hit) begin
								if (count >= MAX_SLOTS) begin
									full = 1;
									s.outc = OUT_OVERFLOW;
								end else begin
									nb.l = COORD_W'(cl);
									nb.t = COORD_W'(ct);
									nb.r = COORD_W'(cr);
									nb.b = COORD_W'(cb);
									slots[count] = nb;
									count++;
									s.box  = nb;
									s.vld  = 1;
									s.outc = OUT_APPENDED;
								end
							end
						end
					end
				end
				ACT_CLEAR: begin
					count = 0;
					full = 0;
				end
				ACT_READ: begin
					if (int'(c.idx) < count) begin
						s.box = slots[c.idx];
						s.vld = 1;
					end
				end
				default: ;
			endcase
			s.full = full;
			s.cnt  = CNT_OUT_W'(count);
			pending.push_back(s);
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTS)
				$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		task cmp(string field, int got, int want);
			if (got != want)
				report($sformatf("%s got %0d, expected %0d", field, got, want));
		endtask

		// Compare a status beat with the oldest one owed
		task check_status(table_status_t got);
			table_status_t want;
			if (pending.size() == 0) begin
				report("status beat with no command outstanding");
			end else begin
				want = pending.pop_front();
				cmp("refresh_request", got.req, want.req);
				cmp("redraw_all", got.full, want.full);
				cmp("region_count", got.cnt, want.cnt);
				cmp("mark_outcome", got.outc, want.outc);
				cmp("out_left", got.box.l, want.box.l);
				cmp("out_top", got.box.t, want.box.t);
				cmp("out_right", got.box.r, want.box.r);
				cmp("out_bottom", got.box.b, want.box.b);
				cmp("out_valid", got.vld, want.vld);
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	drm_item_if   cmd_ch ();
	drm_result_if status_ch ();

	dirty_table_tracker tracker = new();

	bit calm;
	bit hold_off_req;
	int idle_pct;
	int cycle_count;

	dirty_rect_merge_table dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (cmd_ch),
		.result  (status_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	// Status watcher
	always @(posedge clk) begin : watch_status
		table_status_t got;
		if (arst_n && status_ch.valid && status_ch.ready) begin
			got.req   = status_ch.refresh_request;
			got.full  = status_ch.redraw_all;
			got.cnt   = status_ch.region_count;
			got.outc  = status_ch.mark_outcome;
			got.box.l = status_ch.out_left;
			got.box.t = status_ch.out_top;
			got.box.r = status_ch.out_right;
			got.box.b = status_ch.out_bottom;
			got.vld   = status_ch.out_valid;
			tracker.check_status(got);
		end
	end

	// Receiver: short random stalls, one long hold-off on request
	initial begin : status_sink
		status_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 0;
				status_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				status_ch.ready <= 1'b1;
			end else if (!calm && arst_n && $urandom_range(0, 99) < idle_pct) begin
				status_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				status_ch.ready <= 1'b1;
			end else begin
				status_ch.ready <= arst_n;
			end
		end
	end

	// Run limit
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic rect_cmd_t mk(logic [1:0] act, int l, int t, int r, int b, int ix);
		rect_cmd_t c;
		c.action = act;
		c.left   = 16'(l);
		c.top    = 16'(t);
		c.right  = 16'(r);
		c.bottom = 16'(b);
		c.idx    = ENTRY_W'(ix);
		return c;
	endfunction

	// Small rectangle near the visible area; coordinates saturate at the 16-bit top
	function automatic int near_coord(int extent, output int far);
		int p;
		p = int'($urandom_range(0, extent + 3)) - 4;
		far = p + int'($urandom_range(0, extent / 4 + 1));
		if (far > 32767)
			far = 32767;
		return (p > 32767) ? 32767 : p;
	endfunction

	function automatic rect_cmd_t random_cmd();
		rect_cmd_t c;
		int sel, l, t, r, b;
		sel = $urandom_range(0, 99);
		c = mk(ACT_MARK, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 7));
		if (sel < 60) begin
			l = near_coord(tracker.scr_w, r);
			t = near_coord(tracker.scr_h, b);
			c = mk(ACT_MARK, l, t, r, b, c.idx);
		end else if (sel < 70) begin
			c.action = ACT_MARK;
		end else if (sel < 76) begin
			c.action = ACT_CLEAR;
		end else if (sel < 97) begin
			c.action = ACT_READ;
		end else begin
			c.action = ACT_SPARE;
		end
		return c;
	endfunction

	// Drive one command beat; called on a rising edge, returns on the accepting edge
	task automatic send_command(rect_cmd_t c);
		cmd_ch.valid       <= 1'b1;
		cmd_ch.action      <= c.action;
		cmd_ch.rect_left   <= c.left;
		cmd_ch.rect_top    <= c.top;
		cmd_ch.rect_right  <= c.right;
		cmd_ch.rect_bottom <= c.bottom;
		cmd_ch.entry_index <= c.idx;
		do @(posedge clk); while (!cmd_ch.ready);
		tracker.note_command(c);
	endtask

	task automatic mark(int l, int t, int r, int b);
		send_command(mk(ACT_MARK, l, t, r, b, 0));
	endtask

	task automatic plain(logic [1:0] act, int ix);
		send_command(mk(act, 0, 0, 0, 0, ix));
	endtask

	// Wait until every owed status has come back, then let the block go quiet
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_reg(idx, APB_DW'(val));
	endtask

	task automatic configure(int en, int w, int h);
		settle();
		write_reg(REG_ENABLE, en);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	task automatic random_phase(int en, int w, int h, int n);
		rect_cmd_t c;
		configure(en, w, h);
		repeat (n) begin
			c = random_cmd();
			send_command(c);
			if (!calm && $urandom_range(0, 99) < idle_pct) begin
				cmd_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
	endtask

	// Directed corners on the reset configuration and at the register extremes
	task automatic directed_checks();
		// empty table, spare code, off-screen, full-range clip
		plain(ACT_READ, 0);
		plain(ACT_SPARE, 7);
		mark(-100, -100, -1, -1);
		mark(-32768, -32768, 32767, 32767);
		plain(ACT_READ, 0);
		plain(ACT_CLEAR, 0);
		// touching merges, one-pixel gap appends
		mark(10, 10, 20, 20);
		mark(21, 10, 30, 20);
		mark(32, 10, 40, 20);
		mark(100, 100, 110, 110);
		mark(200, 200, 210, 210);
		mark(300, 300, 310, 310);
		mark(400, 400, 410, 410);
		mark(100, 300, 110, 310);
		mark(479, 479, 600, 600);
		// table full: overflow
		mark(450, 20, 460, 30);
		plain(ACT_READ, 7);
		plain(ACT_CLEAR, 3);
		// disabled marks force full refresh and empty the table
		configure(0, 480, 480);
		mark(10, 10, 20, 20);
		plain(ACT_READ, 0);
		// one-pixel, largest and zero screens
		configure(1, 1, 1);
		mark(0, 0, 5, 5);
		configure(1, 32767, 32767);
		mark(-5, -5, 32767, 32767);
		configure(1, 0, 0);
		mark(0, 0, 10, 10);
	endtask

	initial begin : stimulus
		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		cmd_ch.valid        <= 1'b0;
		cmd_ch.action       <= ACT_MARK;
		cmd_ch.rect_left    <= '0;
		cmd_ch.rect_top     <= '0;
		cmd_ch.rect_right   <= '0;
		cmd_ch.rect_bottom  <= '0;
		cmd_ch.entry_index  <= '0;
		calm = 0;
		hold_off_req = 0;
		idle_pct = 15;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_checks();

		// random phases across settings; a long status stall is requested before the first one
		hold_off_req = 1;
		random_phase(1, 64, 48, 240);
		idle_pct = 30;
		random_phase(1, 480, 480, 220);
		idle_pct = 5;
		random_phase(0, 480, 480, 40);
		random_phase(1, 32767, 32767, 140);
		idle_pct = 20;
		random_phase(1, 1, 1, 60);
		random_phase(1, 16, 16, 180);
		calm = 1;
		random_phase(1, 480, 272, 240);
		settle();

		if (tracker.pending.size() != 0)
			tracker.report("status beats still outstanding at the end");
		if (tracker.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
rtl/drm_pkg.sv
rtl/drm_if.sv
rtl/drm_ram.sv
rtl/drm_box.sv
rtl/drm_apb.sv
rtl/dirty_rect_merge_table.sv
bench/dirty_rect_merge_table_tb.sv
